// ----- hw/rtl/cdq_pkg.sv -----
`default_nettype none
package cdq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int IO_W     = 32;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic op_en;
    logic rd_en;
  } cdq_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cdq_ram.sv -----
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cdq_ctrl.sv -----
`default_nettype none
module cdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cdq_pkg::cdq_cmd_t     cmd
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.op_en = in_valid && in_ready;
  assign cmd.rd_en = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op_en |=> cmd.rd_en)
    else $error("accepted item not followed by a store read");

  a_read_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> out_valid && !in_ready)
    else $error("store read not followed by a result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> !cmd.op_en && !cmd.rd_en)
    else $error("new work started while result is stalled");

endmodule
`default_nettype wire

// ----- hw/rtl/cdq_dp.sv -----
`default_nettype none
module cdq_dp #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cdq_pkg::cdq_cmd_t                 cmd,
  input  wire logic [cdq_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [cdq_pkg::IO_W-1:0]   in_value,
  output logic [$clog2(CAPACITY+1)-1:0]          out_count,
  output logic signed [cdq_pkg::IO_W-1:0]        out_front_value,
  output logic signed [cdq_pkg::IO_W-1:0]        out_back_value,
  output logic [cdq_pkg::STATUS_W-1:0]           out_status
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CAP_S  = SUM_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);

  logic [IDX_W-1:0]    head_r;
  logic [IDX_W-1:0]    head_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;

  logic                  full;
  logic                  empty;
  logic [IDX_W-1:0]      head_dec;
  logic [IDX_W-1:0]      head_inc;
  logic [SUM_W-1:0]      tail_sum;
  logic [IDX_W-1:0]      tail_idx;
  logic [SUM_W-1:0]      back_sum;
  logic [IDX_W-1:0]      back_idx;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] back_data;
  logic [IO_W-1:0]       front_32;
  logic [IO_W-1:0]       back_32;

  assign full     = (count_r == CAP_C);
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? LAST_I : head_r - IDX_W'(1);
  assign head_inc = (head_r == LAST_I) ? '0 : head_r + IDX_W'(1);

  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= CAP_S) ? IDX_W'(tail_sum - CAP_S) : IDX_W'(tail_sum);
  assign back_sum = tail_sum - SUM_W'(1);
  assign back_idx = empty ? head_r :
                    (back_sum >= CAP_S) ? IDX_W'(back_sum - CAP_S) : IDX_W'(back_sum);

  generate
    if (DATA_WIDTH <= IO_W) begin : g_narrow
      assign ram_wdata = in_value[DATA_WIDTH-1:0];
      assign front_32  = IO_W'(front_data);
      assign back_32   = IO_W'(back_data);
    end else begin : g_wide
      assign ram_wdata = DATA_WIDTH'(in_value[IO_W-1:0]);
      assign front_32  = front_data[IO_W-1:0];
      assign back_32   = back_data[IO_W-1:0];
    end
  endgenerate

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = tail_idx;
    if (cmd.op_en) begin
      status_nxt = ST_DONE;
      case (in_mode)
        MODE_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        MODE_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_DONE;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.rd_en),
    .raddr_a (head_r),
    .raddr_b (back_idx),
    .rdata_a (front_data),
    .rdata_b (back_data)
  );

  assign out_count       = count_r;
  assign out_status      = status_r;
  assign out_front_value = empty ? '0 : front_32;
  assign out_back_value  = empty ? '0 : back_32;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(head_r) < CAP_S)
    else $error("head index out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op_en && in_mode == MODE_CLEAR |=> count_r == '0 && head_r == '0)
    else $error("clear left entries behind");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op_en && full && (in_mode == MODE_PUSH_BACK || in_mode == MODE_PUSH_FRONT)
    |=> $stable(count_r) && $stable(head_r) && status_r == ST_FULL)
    else $error("push on full changed state");

endmodule
`default_nettype wire

// ----- hw/rtl/circular_deque.sv -----
// circular_deque: double-ended queue in a circular store of CAPACITY entries.
// Input channel (in_valid/in_ready): in_mode selects push back, pop back,
// push front, pop front or clear; in_value is the element for pushes.
// Result channel (out_valid/out_ready): one result per item with the entry
// count, the front and back elements (zero when empty) and a status
// (done, pop on empty ignored, push on full dropped).
// Sequence: an accepted item first updates head, count and the written
// entry; then front and back are read from the registered-read store
// into the result. One item is in flight at a time, so a new item is
// not taken until the result of the last one has been taken; the
// two-port store read after each update is why.
// Reset: head and count go to zero, the deque reads as empty. Store
// contents are not cleared; only pushed entries ever reach the outputs.
// Stall: while out_ready is low the result holds and in_ready stays low.
`default_nettype none
module circular_deque #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [cdq_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [cdq_pkg::IO_W-1:0]   in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [$clog2(CAPACITY+1)-1:0]          out_count,
  output logic signed [cdq_pkg::IO_W-1:0]        out_front_value,
  output logic signed [cdq_pkg::IO_W-1:0]        out_back_value,
  output logic [cdq_pkg::STATUS_W-1:0]           out_status
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire
